// ===== hw/rtl/i2cmer_pkg.sv =====
`timescale 1ns / 1ps
// Package for the I2C master register block with its preloaded byte store.
// Holds operation, register offset and error codes. No dependencies.
package i2cmer_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_LOAD  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_UNKNOWN = 2'd1,
        ERR_CTRL    = 2'd2,
        ERR_SPARE   = 2'd3
    } err_t;

    localparam logic [5:0] ADDR_TX       = 6'h00;
    localparam logic [5:0] ADDR_RX       = 6'h04;
    localparam logic [5:0] ADDR_CTRL     = 6'h08;
    localparam logic [5:0] ADDR_ISER     = 6'h0C;
    localparam logic [5:0] ADDR_ISR      = 6'h10;
    localparam logic [5:0] ADDR_STATUS   = 6'h14;
    localparam logic [5:0] ADDR_TX_LVL   = 6'h18;
    localparam logic [5:0] ADDR_RX_LVL   = 6'h1C;
    localparam logic [5:0] ADDR_SCL_LOW  = 6'h20;
    localparam logic [5:0] ADDR_SCL_HIGH = 6'h24;
    localparam logic [5:0] ADDR_SDA_HOLD = 6'h28;

    // Bit of a TX write that marks a start condition.
    localparam int TX_START_BIT = 9;

    localparam logic [31:0] CTRL_DISABLE = 32'd0;
    localparam logic [31:0] CTRL_ENABLE  = 32'd1;

endpackage

// ===== hw/rtl/i2cmer_in_if.sv =====
`timescale 1ns / 1ps
// Request channel: one bus access per item, valid/ready handshake.
// Depends on nothing.
interface i2cmer_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [5:0]  reg_addr;
    logic [31:0] write_data;
    logic [7:0]  mem_index;

    modport source (output valid, output operation, output reg_addr,
                    output write_data, output mem_index, input ready);
    modport sink   (input valid, input operation, input reg_addr,
                    input write_data, input mem_index, output ready);
endinterface

// ===== hw/rtl/i2cmer_out_if.sv =====
`timescale 1ns / 1ps
// Response channel: one result item per access, valid/ready handshake.
// Depends on nothing.
interface i2cmer_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       irq_pulse;
    logic [1:0] error_code;

    modport source (output valid, output read_data, output irq_pulse,
                    output error_code, input ready);
    modport sink   (input valid, input read_data, input irq_pulse,
                    input error_code, output ready);
endinterface

// ===== hw/rtl/i2c_master_eeprom_responder.sv =====
`timescale 1ns / 1ps
// I2C master register block that answers receive reads from a preloaded byte store.
// Depends on i2cmer_pkg, i2cmer_in_if and i2cmer_out_if.

// The block takes one access item per cycle and presents its result in an output
// register in the cycle after acceptance; the request side keeps accepting as
// long as the output register is empty or is being emptied in the same cycle.
// All register state updates at the edge that accepts the item, and the byte
// store is read synchronously at the current read offset on that same edge,
// so a receive pop returns the byte from the store's registered read port.
// The store is a single memory of STORE_DEPTH bytes with one write and one
// read port; its contents are undefined until loaded.
module i2c_master_eeprom_responder
    import i2cmer_pkg::*;
#(
    parameter int STORE_DEPTH = 256,
    parameter int LEVEL_MAX   = 255
)
(
    input  logic         clk,
    input  logic         rst_n,
    i2cmer_in_if.sink    req,
    i2cmer_out_if.source rsp
);

    localparam int              IDX_W    = $clog2(STORE_DEPTH);
    localparam logic [15:0]     DEPTH_W  = 16'(STORE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_DEPTH - 1);
    localparam logic [7:0]      LEVEL_TOP = 8'(LEVEL_MAX);

    // Reduces a byte modulo the store depth by shifted compare and subtract.
    function automatic logic [IDX_W-1:0] wrap_index(input logic [7:0] value);
        logic [15:0] rem;
        rem = {8'd0, value};
        for (int k = 7; k >= 0; k--)
        begin
            if (rem >= (DEPTH_W << k))
            begin
                rem = rem - (DEPTH_W << k);
            end
        end
        return rem[IDX_W-1:0];
    endfunction

    logic             enabled_reg, enabled_next;
    logic             tx_ie_reg, tx_ie_next;
    logic             rx_ie_reg, rx_ie_next;
    logic             wr_dir_reg, wr_dir_next;
    logic [7:0]       rx_level_reg, rx_level_next;
    logic [IDX_W-1:0] offset_reg, offset_next;

    logic       rsp_valid_reg;
    logic [7:0] rd_val_reg, rd_val_next;
    logic       pop_reg, pop_next;
    logic       irq_reg, irq_next;
    err_t       err_reg, err_next;
    logic [7:0] mem_rd_reg;

    logic [7:0] mem [STORE_DEPTH];

    logic accept;
    op_t  op;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign op        = op_t'(req.operation);

    always_comb
    begin
        enabled_next  = enabled_reg;
        tx_ie_next    = tx_ie_reg;
        rx_ie_next    = rx_ie_reg;
        wr_dir_next   = wr_dir_reg;
        rx_level_next = rx_level_reg;
        offset_next   = offset_reg;
        rd_val_next   = 8'd0;
        pop_next      = 1'b0;
        irq_next      = 1'b0;
        err_next      = ERR_OK;
        unique case (op)
            OP_READ:
            begin
                unique case (req.reg_addr)
                    ADDR_RX:
                    begin
                        if (rx_level_reg != 8'd0)
                        begin
                            pop_next      = 1'b1;
                            rx_level_next = rx_level_reg - 8'd1;
                            offset_next   = (offset_reg == LAST_IDX) ? '0
                                            : offset_reg + IDX_W'(1);
                        end
                    end
                    ADDR_CTRL:   rd_val_next = {7'd0, enabled_reg};
                    ADDR_ISER:   rd_val_next = {6'd0, rx_ie_reg, tx_ie_reg};
                    ADDR_ISR:    rd_val_next = {6'd0, rx_level_reg != 8'd0, 1'b1};
                    ADDR_STATUS, ADDR_TX_LVL: rd_val_next = 8'd0;
                    ADDR_RX_LVL: rd_val_next = rx_level_reg;
                    default:     err_next = ERR_UNKNOWN;
                endcase
            end
            OP_WRITE:
            begin
                unique case (req.reg_addr)
                    ADDR_TX:
                    begin
                        if (req.write_data[TX_START_BIT])
                        begin
                            wr_dir_next = !req.write_data[0];
                        end
                        else if (wr_dir_reg)
                        begin
                            offset_next = wrap_index(req.write_data[7:0]);
                            irq_next    = enabled_reg && tx_ie_reg;
                        end
                        else
                        begin
                            if (rx_level_reg < LEVEL_TOP)
                            begin
                                rx_level_next = rx_level_reg + 8'd1;
                            end
                            irq_next = enabled_reg && rx_ie_reg;
                        end
                    end
                    ADDR_CTRL:
                    begin
                        if (req.write_data == CTRL_DISABLE)
                        begin
                            enabled_next = 1'b0;
                        end
                        else if (req.write_data == CTRL_ENABLE)
                        begin
                            enabled_next  = 1'b1;
                            rx_level_next = 8'd0;
                        end
                        else
                        begin
                            err_next = ERR_CTRL;
                        end
                    end
                    ADDR_ISER:
                    begin
                        tx_ie_next = req.write_data[0];
                        rx_ie_next = req.write_data[1];
                    end
                    ADDR_ISR, ADDR_SCL_LOW, ADDR_SCL_HIGH, ADDR_SDA_HOLD: ;
                    default: err_next = ERR_UNKNOWN;
                endcase
            end
            OP_LOAD: ;
            default: err_next = ERR_UNKNOWN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b0;
            tx_ie_reg     <= 1'b0;
            rx_ie_reg     <= 1'b0;
            wr_dir_reg    <= 1'b0;
            rx_level_reg  <= 8'd0;
            offset_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                enabled_reg  <= enabled_next;
                tx_ie_reg    <= tx_ie_next;
                rx_ie_reg    <= rx_ie_next;
                wr_dir_reg   <= wr_dir_next;
                rx_level_reg <= rx_level_next;
                offset_reg   <= offset_next;
            end
            if (req.ready)
            begin
                rsp_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_val_reg <= rd_val_next;
            pop_reg    <= pop_next;
            irq_reg    <= irq_next;
            err_reg    <= err_next;
        end
    end

    // Byte store: load port and a read port addressed by the current offset.
    always_ff @(posedge clk)
    begin
        if (accept && op == OP_LOAD)
        begin
            mem[wrap_index(req.mem_index)] <= req.write_data[7:0];
        end
        if (accept)
        begin
            mem_rd_reg <= mem[offset_reg];
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_data  = pop_reg ? mem_rd_reg : rd_val_reg;
    assign rsp.irq_pulse  = irq_reg;
    assign rsp.error_code = err_reg;

endmodule

// ===== hw/rtl/i2cmer_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the I2C master register block, bound to the top level.
// Depends on i2cmer_pkg and i2c_master_eeprom_responder.
module i2cmer_checker
    import i2cmer_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] read_data,
    input logic       irq_pulse,
    input logic [1:0] error_code
);

    // A held result keeps its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data)
            && $stable(irq_pulse) && $stable(error_code))
        else $error("result changed while stalled");

    // Every accepted item yields a result on the next cycle.
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("accepted item produced no result");

    // With one output stage, a stalled result blocks the request side.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("request accepted while result stalled");

    // An interrupt comes only from a clean TX data write.
    a_irq_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && irq_pulse |-> error_code == ERR_OK && read_data == 8'd0)
        else $error("interrupt with error or read data");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> error_code != ERR_SPARE)
        else $error("undefined error code");

endmodule

bind i2c_master_eeprom_responder i2cmer_checker u_i2cmer_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .read_data  (rsp.read_data),
    .irq_pulse  (rsp.irq_pulse),
    .error_code (rsp.error_code)
);
